[hw/rtl/rdq_pkg.sv]
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and constants of the reversible deque
// Operation and status codes, beat structs for the command and response
// channels, and default sizing.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_REVERSE    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic [STATUS_W-1:0]      status;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

endpackage

[hw/rtl/reversible_deque_unit.sv]
// ----------------------------------------------------------------------------
// reversible_deque_unit: bounded double-ended queue with constant-time reverse
// Ring of DEPTH signed 32-bit entries; push/pop at either end, reverse.
// ----------------------------------------------------------------------------
// The deque takes one command beat per cycle while the response side does not
// stall, and returns exactly one response beat per command, in order, through
// stage 1 and the output register. Entries live in a RAM with a registered
// read; the first-slot pointer, entry count and orientation flag are
// registers updated in the accept cycle, and the RAM read of a pop completes
// in the next cycle. A push reaches the RAM before any later pop can read it,
// so back-to-back commands need no forwarding. A pop on an empty deque
// returns zero with status empty; a push on a full deque is dropped with
// status full. Reverse toggles which physical end is the logical front.
// Occupancy reports the entry count after the command, in its low seven bits.
module reversible_deque_unit #(
	parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  rdq_pkg::cmd_t cmd,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output rdq_pkg::rsp_t rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// pointer state
	logic [IDX_W-1:0] first_q, first_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             rev_q, rev_d;

	// pipeline and output registers
	logic                 valid_s1;
	logic                 pop_s1;
	rdq_pkg::status_t     status_s1;
	logic [CNT_W-1:0]     count_s1;
	logic                 rsp_valid_q;
	rdq_pkg::rsp_t        rsp_q;

	// combinational
	logic                 cmd_acc;
	logic                 out_free;
	logic                 wr_en, rd_en, wr_req, rd_req;
	logic [IDX_W-1:0]     wr_addr, rd_addr;
	logic [rdq_pkg::DATA_W-1:0] rd_data;
	logic                 pop_d;
	rdq_pkg::status_t     status_d;
	logic [SUM_W-1:0]     tail_sum, last_sum;
	logic [IDX_W-1:0]     tail_slot, last_slot, prev_first, next_first;

	// handshake
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || out_free;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ring slot arithmetic
	always_comb begin
		tail_sum = SUM_W'(first_q) + SUM_W'(count_q);
		last_sum = tail_sum - SUM_W'(1);
		if (tail_sum >= SUM_W'(DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(DEPTH);
		end
		if (last_sum >= SUM_W'(DEPTH)) begin
			last_sum = last_sum - SUM_W'(DEPTH);
		end
		tail_slot  = tail_sum[IDX_W-1:0];
		last_slot  = last_sum[IDX_W-1:0];
		prev_first = (first_q == '0) ? IDX_W'(DEPTH - 1) : first_q - IDX_W'(1);
		next_first = (first_q == IDX_W'(DEPTH - 1)) ? '0 : first_q + IDX_W'(1);
	end

	// decode the command: next pointer state and RAM access
	always_comb begin
		first_d  = first_q;
		count_d  = count_q;
		rev_d    = rev_q;
		wr_req   = 1'b0;
		wr_addr  = tail_slot;
		rd_req   = 1'b0;
		rd_addr  = first_q;
		pop_d    = 1'b0;
		status_d = rdq_pkg::ST_DONE;
		unique case (cmd.operation)
			rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
				if (count_q == CNT_W'(DEPTH)) begin
					status_d = rdq_pkg::ST_FULL;
				end else begin
					wr_req  = 1'b1;
					count_d = count_q + CNT_W'(1);
					if ((cmd.operation == rdq_pkg::OP_PUSH_FRONT) != rev_q) begin
						first_d = prev_first;
						wr_addr = prev_first;
					end
				end
			end
			rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
				if (count_q == '0) begin
					status_d = rdq_pkg::ST_EMPTY;
				end else begin
					rd_req  = 1'b1;
					pop_d   = 1'b1;
					count_d = count_q - CNT_W'(1);
					if ((cmd.operation == rdq_pkg::OP_POP_FRONT) != rev_q) begin
						first_d = next_first;
					end else begin
						rd_addr = last_slot;
					end
				end
			end
			rdq_pkg::OP_REVERSE: begin
				rev_d = !rev_q;
			end
			default: begin
			end
		endcase
	end

	assign wr_en = wr_req && cmd_acc;
	assign rd_en = rd_req && cmd_acc;

	rdq_ram #(
		.WIDTH (rdq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// advance pointer state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd_acc) begin
			first_q <= first_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

	// stage 1: hold result metadata while the RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			pop_s1    <= pop_d;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	// output register: take the stage 1 beat when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q.popped_value <= pop_s1 ? signed'(rd_data) : '0;
			rsp_q.status       <= status_s1;
			rsp_q.occupancy    <= rdq_pkg::OCC_W'(count_s1);
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == rdq_pkg::ST_FULL |->
			rsp.occupancy == rdq_pkg::OCC_W'(DEPTH) && rsp.popped_value == '0)
		else $error("full response with wrong occupancy or value");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == rdq_pkg::ST_EMPTY |->
			rsp.occupancy == '0 && rsp.popped_value == '0)
		else $error("empty response with wrong occupancy or value");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> valid_s1)
		else $error("accepted beat lost before stage 1");

endmodule

[hw/rtl/rdq_ram.sv]
// ----------------------------------------------------------------------------
// rdq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rdq_ram #(
	parameter int WIDTH = rdq_pkg::DATA_W,
	parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// register the read data, hold it between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the reversible deque
// A clocked driver sends command beats from a pending list in random bursts.
// A clocked monitor stalls the response side on its own pattern and checks
// each response beat against a shadow deque that is updated on every
// accepted command. The stimulus is a short directed opening, then fill,
// drain and mixed phases with random content.
// ----------------------------------------------------------------------------
module tb_top;
	import rdq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int SLOT_W       = $clog2(DEPTH);
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 200_000;

	// command codes the block does not define
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow deque
	logic signed [DATA_W-1:0] shadow_store [DEPTH];
	logic [SLOT_W-1:0]        shadow_first    = '0;
	logic [OCC_W-1:0]         shadow_count    = '0;
	logic                     shadow_reversed = 1'b0;

	cmd_t pending_cmd [$];
	rsp_t expected_rsp [$];

	int n_errors = 0;
	int n_sent = 0;
	int n_rsp = 0;
	int n_push_ok = 0;
	int n_pop_ok = 0;
	int n_push_full = 0;
	int n_pop_empty = 0;
	int n_reverse = 0;
	int n_spare = 0;
	int peak_count = 0;
	int cycle_count = 0;

	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	reversible_deque_unit #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Apply one command to the shadow deque and return the response it earns.
	function automatic rsp_t deque_apply(cmd_t c);
		rsp_t r;
		logic at_first;
		logic [OCC_W-1:0] tail;
		logic [SLOT_W-1:0] slot;
		r = '0;
		r.status = ST_DONE;
		case (c.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_count == OCC_W'(DEPTH)) begin
					r.status = ST_FULL;
					n_push_full++;
				end else begin
					// logical front is the physical first slot unless reversed
					at_first = (c.operation == OP_PUSH_FRONT) ^ shadow_reversed;
					if (at_first) begin
						shadow_first = shadow_first - SLOT_W'(1);
						shadow_store[shadow_first] = c.value;
					end else begin
						slot = shadow_first + shadow_count[SLOT_W-1:0];
						shadow_store[slot] = c.value;
					end
					shadow_count = shadow_count + OCC_W'(1);
					n_push_ok++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_count == '0) begin
					r.status = ST_EMPTY;
					n_pop_empty++;
				end else begin
					at_first = (c.operation == OP_POP_FRONT) ^ shadow_reversed;
					if (at_first) begin
						r.popped_value = shadow_store[shadow_first];
						shadow_first = shadow_first + SLOT_W'(1);
					end else begin
						tail = shadow_count - OCC_W'(1);
						slot = shadow_first + tail[SLOT_W-1:0];
						r.popped_value = shadow_store[slot];
					end
					shadow_count = shadow_count - OCC_W'(1);
					n_pop_ok++;
				end
			end
			OP_REVERSE: begin
				shadow_reversed = ~shadow_reversed;
				n_reverse++;
			end
			default: begin
				n_spare++;
			end
		endcase
		r.occupancy = shadow_count;
		if (int'(shadow_count) > peak_count)
			peak_count = int'(shadow_count);
		return r;
	endfunction

	// Favor the edge values of a signed word, otherwise any pattern.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Pick a command; push_pct weights pushes against pops.
	function automatic logic [OP_W-1:0] pick_op(int push_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < 2)
			return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (roll < 9)
			return OP_REVERSE;
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	task automatic queue_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
		cmd_t c;
		c.operation = op;
		c.value = val;
		pending_cmd.push_back(c);
	endtask

	// Drive command beats: hold while stalled, advance on acceptance.
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		logic next_valid;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				expected_rsp.push_back(deque_apply(cmd));
				n_sent++;
			end
			if (!cmd_valid || cmd_ready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmd.size() > 0) begin
					next_valid = 1'b1;
					cmd <= pending_cmd.pop_front();
					// end of burst: choose the next gap and burst length
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = $urandom_range(1) ? 0 : $urandom_range(1, 6);
					end
				end
				cmd_valid <= next_valid;
			end
		end
	end

	// Check response beats and stall the response side.
	always @(posedge clk or negedge arst_n) begin : check_rsp
		rsp_t want;
		logic next_ready;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (expected_rsp.size() == 0) begin
					$error("response beat with none expected: value %0d status %0d occ %0d",
						rsp.popped_value, rsp.status, rsp.occupancy);
					n_errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, rsp.popped_value);
						n_errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						n_errors++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, rsp.occupancy);
						n_errors++;
					end
				end
			end
			// switch the stall pattern now and then
			if (stall_left == 0) begin
				stall_mode = $urandom_range(3);
				stall_left = $urandom_range(20, 300);
			end else begin
				stall_left--;
			end
			stall_phase++;
			case (stall_mode)
				0: next_ready = 1'b1;
				1: next_ready = ($urandom_range(99) < 75);
				2: next_ready = ($urandom_range(99) < 30);
				default: next_ready = ((stall_phase % 5) >= 2);
			endcase
			rsp_ready <= next_ready;
		end
	end

	initial begin : stimulus
		int n_random;
		int seg_len;
		int push_pct;
		// opening: empty pops, reverse while empty, edge values, spare codes
		queue_cmd(OP_POP_FRONT, 32'h1234_5678);
		queue_cmd(OP_POP_BACK, '1);
		queue_cmd(OP_REVERSE, '0);
		queue_cmd(OP_REVERSE, '1);
		queue_cmd(OP_PUSH_FRONT, 32'h7fff_ffff);
		queue_cmd(OP_PUSH_BACK, 32'h8000_0000);
		queue_cmd(OP_PUSH_FRONT, '1);
		queue_cmd(OP_PUSH_BACK, '0);
		queue_cmd(OP_PUSH_FRONT, 32'h5555_5555);
		queue_cmd(OP_PUSH_BACK, 32'haaaa_aaaa);
		queue_cmd(OP_REVERSE, '0);
		queue_cmd(OP_POP_FRONT, '0);
		queue_cmd(OP_POP_BACK, '0);
		queue_cmd(OP_PUSH_FRONT, 32'h0000_0001);
		for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
			queue_cmd(OP_W'(op), pick_value());
		queue_cmd(OP_POP_FRONT, '0);
		queue_cmd(OP_POP_BACK, '0);
		queue_cmd(OP_REVERSE, '0);
		queue_cmd(OP_POP_FRONT, '0);
		queue_cmd(OP_POP_BACK, '0);
		queue_cmd(OP_POP_FRONT, '0);
		queue_cmd(OP_POP_BACK, '0);

		// random phases: fill past full, drain past empty, then a mix
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			if (n_random == 0) begin
				push_pct = 90;
				seg_len = 130;
			end else if (n_random < 150) begin
				push_pct = 10;
				seg_len = 130;
			end else begin
				case ($urandom_range(2))
					0: push_pct = 90;
					1: push_pct = 10;
					default: push_pct = 50;
				endcase
				seg_len = $urandom_range(40, 120);
			end
			// trim the last segment to the item budget
			if (seg_len > RANDOM_ITEMS - n_random)
				seg_len = RANDOM_ITEMS - n_random;
			repeat (seg_len)
				queue_cmd(pick_op(push_pct), pick_value());
			n_random += seg_len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmd.size() > 0 || cmd_valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands, %0d responses: %0d pushes, %0d pops, %0d reverses,",
			n_sent, n_rsp, n_push_ok, n_pop_ok, n_reverse);
		$display("  %0d pushes on full, %0d pops on empty, %0d spare codes, peak occupancy %0d",
			n_push_full, n_pop_empty, n_spare, peak_count);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// end a hung run
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_ram.sv
hw/rtl/reversible_deque_unit.sv
tb/tb_top.sv
